// ===== hw/rtl/irvb_pkg.sv =====
package irvb_pkg;

    localparam int FullSweepStepsDefault = 105;

    localparam logic [5:0] VolTop     = 6'd39;
    localparam logic [5:0] VolReset   = 6'd20;
    localparam logic [5:0] RightMax   = 6'd38;
    localparam logic [7:0] BalCenter  = 8'd100;

    localparam logic [31:0] CodeMute   = 32'h00ff_b24d;
    localparam logic [31:0] CodeMax    = 32'h00ff_6897;
    localparam logic [31:0] CodeUp     = 32'h00ff_7887;
    localparam logic [31:0] CodeDown   = 32'h00ff_50af;
    localparam logic [31:0] CodeStore  = 32'h00ff_32cd;
    localparam logic [31:0] CodeRepeat = 32'hffff_ffff;
    localparam logic [31:0] CodeBalUp  = 32'h00ff_e817;
    localparam logic [31:0] CodeBalMid = 32'h00ff_a857;
    localparam logic [31:0] CodeBalDn  = 32'h00ff_8877;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_SET        = 3'd1,
        ACT_SWEEP_ZERO = 3'd2,
        ACT_SWEEP_MAX  = 3'd3,
        ACT_STORE      = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        REP_NONE = 2'd0,
        REP_UP   = 2'd1,
        REP_DOWN = 2'd2
    } t_repeat;

    typedef struct packed {
        logic [5:0] volume;
        logic [7:0] balance;
        t_repeat    repeatable;
    } t_state;

    // field order from lowest bit up: action, left, right, volume, balance
    typedef struct packed {
        logic [7:0] balance_now;
        logic [5:0] volume_now;
        logic [6:0] right_steps;
        logic [6:0] left_steps;
        t_action    action;
    } t_result;

    // up pulses for a volume index: full scale minus the log attenuation table
    function automatic logic [6:0] step_count(input logic [5:0] idx);
        logic [6:0] s;
        begin
            case (idx)
                6'd0:  s = 7'd0;   6'd1:  s = 7'd1;   6'd2:  s = 7'd2;
                6'd3:  s = 7'd3;   6'd4:  s = 7'd4;   6'd5:  s = 7'd5;
                6'd6:  s = 7'd6;   6'd7:  s = 7'd7;   6'd8:  s = 7'd8;
                6'd9:  s = 7'd9;   6'd10: s = 7'd10;  6'd11: s = 7'd11;
                6'd12: s = 7'd12;  6'd13: s = 7'd13;  6'd14: s = 7'd14;
                6'd15: s = 7'd15;  6'd16: s = 7'd16;  6'd17: s = 7'd17;
                6'd18: s = 7'd18;  6'd19: s = 7'd19;  6'd20: s = 7'd20;
                6'd21: s = 7'd23;  6'd22: s = 7'd25;  6'd23: s = 7'd28;
                6'd24: s = 7'd31;  6'd25: s = 7'd34;  6'd26: s = 7'd37;
                6'd27: s = 7'd41;  6'd28: s = 7'd44;  6'd29: s = 7'd48;
                6'd30: s = 7'd53;  6'd31: s = 7'd57;  6'd32: s = 7'd62;
                6'd33: s = 7'd68;  6'd34: s = 7'd73;  6'd35: s = 7'd79;
                6'd36: s = 7'd85;  6'd37: s = 7'd91;  6'd38: s = 7'd100;
                default: s = 7'd0;
            endcase
            step_count = s;
        end
    endfunction

endpackage

// ===== hw/rtl/ir_volume_balance_controller.sv =====
// Remote-control volume and balance controller for a pair of up/down pots.
// Slave channel: one beat per decoded 32-bit remote code (i_s_tdata).
// Master channel: one beat per code with the pot command: action, left and
// right pulse counts, and the volume index and balance offset after the code.
// Every accepted code produces exactly one result beat, unknown codes too
// (action none, state unchanged).
// Result path: input register, then the command decode into the result
// register. Throughput: one code per cycle unless the receiver stalls;
// the decode and table lookup sit in the single stage between the input
// and result registers, and the state registers update as a code moves
// into the result register.
// Reset (synchronous, active low): volume index 20, balance 100 (centered),
// nothing to repeat, both stages empty.
// Receiver stall: the result register holds its beat, the input register
// fills behind it, then o_s_tready drops until the master side drains.
module ir_volume_balance_controller
    import irvb_pkg::*;
#(
    parameter int FULL_SWEEP_STEPS = FullSweepStepsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] ir_code
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [2:0] action, [9:3] left_steps, [16:10] right_steps,
    // [22:17] volume_now, [30:23] balance_now, [31] zero
    output logic [31:0] o_m_tdata
);

    logic        r_in_valid;
    logic [31:0] r_in_code;
    logic        r_out_valid;
    t_result     r_out;
    t_state      r_state;

    t_state      n_state;
    t_result     n_out;
    logic        out_free;
    logic        advance;
    logic        in_take;

    // result register frees when empty or its beat is taken this cycle
    assign out_free   = !r_out_valid || i_m_tready;
    assign advance    = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || advance;
    assign in_take    = i_s_tvalid && o_s_tready;

    irvb_cmd_core #(
        .FULL_SWEEP_STEPS(FULL_SWEEP_STEPS)
    ) u_core (
        .i_code  (r_in_code),
        .i_state (r_state),
        .o_state (n_state),
        .o_result(n_out)
    );

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid         <= 1'b0;
            r_out_valid        <= 1'b0;
            r_state.volume     <= VolReset;
            r_state.balance    <= BalCenter;
            r_state.repeatable <= REP_NONE;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            // commit the state only when the code moves on
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    // payload: load input on accept, result on advance
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_code <= i_s_tdata;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out};

endmodule

// ===== hw/rtl/irvb_cmd_core.sv =====
module irvb_cmd_core
    import irvb_pkg::*;
#(
    parameter int FULL_SWEEP_STEPS = FullSweepStepsDefault
) (
    input  logic [31:0] i_code,
    input  t_state      i_state,
    output t_state      o_state,
    output t_result     o_result
);

    localparam logic [6:0] SweepSteps = 7'(FULL_SWEEP_STEPS);

    t_state     nxt;
    logic       do_apply;
    t_action    act;
    logic [6:0] left_s;
    logic [6:0] right_s;
    logic [8:0] right_raw;
    logic [5:0] right_idx;

    // decode the button and move the state
    always_comb begin
        nxt      = i_state;
        do_apply = 1'b0;
        act      = ACT_NONE;
        left_s   = 7'd0;
        right_s  = 7'd0;
        case (i_code)
            CodeMute: begin
                nxt.repeatable = REP_NONE;
                nxt.volume     = 6'd0;
                act            = ACT_SWEEP_ZERO;
                left_s         = SweepSteps;
                right_s        = SweepSteps;
            end
            CodeMax: begin
                nxt.repeatable = REP_NONE;
                nxt.volume     = VolTop;
                act            = ACT_SWEEP_MAX;
                left_s         = SweepSteps;
                right_s        = SweepSteps;
            end
            CodeUp: begin
                nxt.repeatable = REP_UP;
                if (i_state.volume < VolTop) begin
                    nxt.volume = i_state.volume + 6'd1;
                    do_apply   = 1'b1;
                end
            end
            CodeDown: begin
                nxt.repeatable = REP_DOWN;
                if (i_state.volume != 6'd0) begin
                    nxt.volume = i_state.volume - 6'd1;
                    do_apply   = 1'b1;
                end
            end
            CodeStore: begin
                nxt.repeatable = REP_NONE;
                act            = ACT_STORE;
            end
            CodeBalUp: begin
                nxt.repeatable = REP_NONE;
                nxt.balance    = i_state.balance + 8'd1;
                do_apply       = 1'b1;
            end
            CodeBalDn: begin
                nxt.repeatable = REP_NONE;
                nxt.balance    = i_state.balance - 8'd1;
                do_apply       = 1'b1;
            end
            CodeBalMid: begin
                nxt.repeatable = REP_NONE;
                nxt.balance    = BalCenter;
                do_apply       = 1'b1;
            end
            CodeRepeat: begin
                if (i_state.repeatable == REP_UP && i_state.volume < VolTop) begin
                    nxt.volume = i_state.volume + 6'd1;
                    do_apply   = 1'b1;
                end else if (i_state.repeatable == REP_DOWN && i_state.volume != 6'd0) begin
                    nxt.volume = i_state.volume - 6'd1;
                    do_apply   = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // right index: volume minus balance offset from center, clamped to the table
        right_raw = 9'({3'b000, nxt.volume}) + 9'(BalCenter) - 9'({1'b0, nxt.balance});
        if (right_raw[8]) begin
            right_idx = 6'd0;
        end else if (right_raw[7:0] > 8'(RightMax)) begin
            right_idx = RightMax;
        end else begin
            right_idx = right_raw[5:0];
        end

        // top of the range has no table entry: no pot command
        if (do_apply && nxt.volume < VolTop) begin
            act     = ACT_SET;
            left_s  = step_count(nxt.volume);
            right_s = step_count(right_idx);
        end
    end

    assign o_state              = nxt;
    assign o_result.action      = act;
    assign o_result.left_steps  = left_s;
    assign o_result.right_steps = right_s;
    assign o_result.volume_now  = nxt.volume;
    assign o_result.balance_now = nxt.balance;

endmodule

// ===== tb/ir_volume_balance_controller_test.sv =====
`timescale 1ns / 1ps

module ir_volume_balance_controller_test;
    import irvb_pkg::*;

    // Attenuation per volume index; the pot gets full scale minus this many up pulses.
    localparam logic [6:0] ATTEN_LOG [39] = '{
        7'd100, 7'd99, 7'd98, 7'd97, 7'd96, 7'd95, 7'd94, 7'd93, 7'd92, 7'd91,
        7'd90,  7'd89, 7'd88, 7'd87, 7'd86, 7'd85, 7'd84, 7'd83, 7'd82, 7'd81,
        7'd80,  7'd77, 7'd75, 7'd72, 7'd69, 7'd66, 7'd63, 7'd59, 7'd56, 7'd52,
        7'd47,  7'd43, 7'd38, 7'd32, 7'd27, 7'd21, 7'd15, 7'd9,  7'd0
    };
    localparam logic [6:0] FULL_SCALE = 7'd100;
    localparam logic [6:0] SWEEP_STEPS = 7'(FullSweepStepsDefault);

    localparam logic [31:0] KNOWN_CODES [9] = '{
        CodeMute, CodeMax, CodeUp, CodeDown, CodeStore,
        CodeRepeat, CodeBalUp, CodeBalMid, CodeBalDn
    };

    localparam int ITEM_TARGET = 650;
    localparam int CALM_AFTER  = 560;   // no idling on either side past this many codes

    // Tracks volume, balance and the repeatable button, and keeps the pot
    // commands that are still owed by the block.
    class pot_command_tracker;
        logic [5:0] volume;
        logic [7:0] balance;
        t_repeat    held_button;
        t_result    owed_cmds[$];
        int         mismatches;
        int         beats_seen;

        function new();
            volume      = VolReset;
            balance     = BalCenter;
            held_button = REP_NONE;
            mismatches  = 0;
            beats_seen  = 0;
        endfunction

        function int pending();
            return owed_cmds.size();
        endfunction

        // Sweep down then step up to the current volume on both pots.
        function void set_pots(inout t_result r);
            int right_idx;
            if (volume >= VolTop) begin
                return;
            end
            right_idx = int'(volume) - (int'(balance) - int'(BalCenter));
            if (right_idx < 0) right_idx = 0;
            if (right_idx > int'(RightMax)) right_idx = int'(RightMax);
            r.action      = ACT_SET;
            r.left_steps  = FULL_SCALE - ATTEN_LOG[volume];
            r.right_steps = FULL_SCALE - ATTEN_LOG[right_idx];
        endfunction

        function void step_up(inout t_result r);
            if (volume < VolTop) begin
                volume++;
                set_pots(r);
            end
        endfunction

        function void step_down(inout t_result r);
            if (volume > 0) begin
                volume--;
                set_pots(r);
            end
        endfunction

        function void note_code(logic [31:0] code);
            t_result r;
            r = '0;
            r.action = ACT_NONE;
            case (code)
                CodeMute: begin
                    held_button = REP_NONE;
                    volume = '0;
                    r.action = ACT_SWEEP_ZERO;
                    r.left_steps = SWEEP_STEPS;
                    r.right_steps = SWEEP_STEPS;
                end
                CodeMax: begin
                    held_button = REP_NONE;
                    volume = VolTop;
                    r.action = ACT_SWEEP_MAX;
                    r.left_steps = SWEEP_STEPS;
                    r.right_steps = SWEEP_STEPS;
                end
                CodeUp: begin
                    held_button = REP_UP;
                    step_up(r);
                end
                CodeDown: begin
                    held_button = REP_DOWN;
                    step_down(r);
                end
                CodeStore: begin
                    held_button = REP_NONE;
                    r.action = ACT_STORE;
                end
                CodeBalUp: begin
                    held_button = REP_NONE;
                    balance = balance + 8'd1;
                    set_pots(r);
                end
                CodeBalDn: begin
                    held_button = REP_NONE;
                    balance = balance - 8'd1;
                    set_pots(r);
                end
                CodeBalMid: begin
                    held_button = REP_NONE;
                    balance = BalCenter;
                    set_pots(r);
                end
                CodeRepeat: begin
                    if (held_button == REP_UP) step_up(r);
                    else if (held_button == REP_DOWN) step_down(r);
                end
                default: ;
            endcase
            r.volume_now  = volume;
            r.balance_now = balance;
            owed_cmds.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH beat %0d: %s", $realtime, beats_seen, what);
            mismatches++;
        endtask

        task check_beat(logic [31:0] data);
            t_result got, want;
            got = t_result'(data[30:0]);
            if (owed_cmds.size() == 0) begin
                report_mismatch($sformatf("unexpected beat %h", data));
            end else begin
                want = owed_cmds.pop_front();
                if (got.action !== want.action)
                    report_mismatch($sformatf("action %0d, want %0d", got.action, want.action));
                if (got.left_steps !== want.left_steps)
                    report_mismatch($sformatf("left_steps %0d, want %0d",
                                              got.left_steps, want.left_steps));
                if (got.right_steps !== want.right_steps)
                    report_mismatch($sformatf("right_steps %0d, want %0d",
                                              got.right_steps, want.right_steps));
                if (got.volume_now !== want.volume_now)
                    report_mismatch($sformatf("volume_now %0d, want %0d",
                                              got.volume_now, want.volume_now));
                if (got.balance_now !== want.balance_now)
                    report_mismatch($sformatf("balance_now %0d, want %0d",
                                              got.balance_now, want.balance_now));
                if (data[31] !== 1'b0)
                    report_mismatch("pad bit 31 not zero");
            end
            beats_seen++;
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = '0;   // [31:0] ir_code
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // [2:0] action, [9:3] left_steps, [16:10] right_steps,
    // [22:17] volume_now, [30:23] balance_now, [31] zero
    logic [31:0] o_m_tdata;

    pot_command_tracker tracker = new();
    int  codes_sent = 0;
    bit  idling     = 1'b1;
    int  stall_left = 0;

    ir_volume_balance_controller i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: check each result beat, stall in short random bursts.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            tracker.check_beat(o_m_tdata);
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (i_rst_n && idling && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Offer one code, optionally after a short gap, and hold it until taken.
    task automatic send_code(input logic [31:0] code);
        if (idling && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= code;
        do @(posedge i_clk); while (!o_s_tready);
        tracker.note_code(code);
        codes_sent++;
        if (codes_sent >= CALM_AFTER) idling = 1'b0;
    endtask

    // Held volume button: one press, then a burst of repeat codes with the
    // odd unknown code in between (it must not drop the held button).
    task automatic run_volume_hold();
        int n;
        n = $urandom_range(0, 10);
        send_code($urandom_range(0, 1) ? CodeUp : CodeDown);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0) send_code($urandom);
            else send_code(CodeRepeat);
        end
    endtask

    // Balance run; now and then long enough to wrap the offset.
    task automatic run_balance();
        int n;
        logic [31:0] dir;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 160) : $urandom_range(1, 12);
        dir = $urandom_range(0, 1) ? CodeBalUp : CodeBalDn;
        repeat (n) send_code(dir);
        if ($urandom_range(0, 3) == 0) send_code(CodeRepeat);
        if ($urandom_range(0, 2) == 0) send_code(CodeBalMid);
    endtask

    task automatic send_noise();
        logic [31:0] c;
        case ($urandom_range(0, 3))
            0: c = $urandom;
            1: c = KNOWN_CODES[$urandom_range(0, 8)] ^ (32'd1 << $urandom_range(0, 31));
            2: c = {$urandom_range(0, 1) ? 8'hff : 8'h00, 24'($urandom)};
            default: c = ~KNOWN_CODES[$urandom_range(0, 8)];
        endcase
        send_code(c);
    endtask

    initial begin
        int wait_cycles;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every button, clamps at both ends, the top-index rule,
        // repeat with and without a held button, and unknown codes.
        send_code(CodeRepeat);          // nothing held yet
        send_code(CodeUp);
        send_code(CodeRepeat);
        send_code(32'h0000_0000);       // unknown, keeps the held button
        send_code(CodeRepeat);
        send_code(CodeDown);
        send_code(CodeRepeat);
        send_code(CodeMute);
        send_code(CodeDown);            // already at the bottom
        send_code(CodeRepeat);
        send_code(CodeUp);
        send_code(CodeBalDn);
        send_code(CodeBalUp);
        send_code(CodeMax);
        send_code(CodeUp);              // already at the top
        send_code(CodeBalUp);           // top index: no pot command
        send_code(CodeDown);
        send_code(CodeBalDn);
        send_code(CodeBalMid);
        send_code(CodeStore);
        send_code(CodeRepeat);          // store cleared the held button
        send_code(32'hffff_fffe);
        send_code(32'h00ff_b24c);
        send_code(32'h7fff_ffff);

        while (codes_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: run_volume_hold();
                4, 5:       run_balance();
                6:          send_code($urandom_range(0, 1) ? CodeMute : CodeMax);
                7:          send_code($urandom_range(0, 1) ? CodeStore : CodeBalMid);
                default:    send_noise();
            endcase
        end
        i_s_tvalid <= 1'b0;
        idling = 1'b0;

        wait_cycles = 0;
        while (tracker.pending() != 0 && wait_cycles < 1000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (8) @(posedge i_clk);

        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (tracker.pending() != 0)
                $display("%0d pot commands never arrived", tracker.pending());
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout after %0d codes", codes_sent);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/irvb_pkg.sv
hw/rtl/irvb_cmd_core.sv
hw/rtl/ir_volume_balance_controller.sv
tb/ir_volume_balance_controller_test.sv
